>>> rtl/core/rsc_pkg.sv
`default_nettype none
package rsc_pkg;

  localparam int unsigned DIV_STEPS  = 89;
  localparam int unsigned MUL_STEPS  = 40;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned T_ROWS     = 99;
  // floor(p / 1000) = (floor(p / 8) * HW_RECIP) >> 46 for p below HW_SAT
  localparam logic [39:0] HW_RECIP   = 40'd562949953422;
  localparam logic [47:0] HW_SAT     = 48'd4294967296000;

  typedef enum logic [1:0] {
    LVL_90 = 2'd0,
    LVL_95 = 2'd1,
    LVL_99 = 2'd2,
    LVL_UNUSED = 2'd3
  } conf_lvl_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCUM, OP_CLEAR, OP_LD_MEAN, OP_DIV_STEP, OP_ST_MEAN,
    OP_MUL_ADD, OP_LD_MUL2, OP_MUL_SUB, OP_LD_VAR, OP_ST_VAR, OP_LD_SD,
    OP_SQ_STEP, OP_ST_SD, OP_LD_SQ2, OP_ST_SE, OP_LD_HW, OP_ST_HW
  } dp_op_e;

  typedef enum logic [4:0] {
    S_ACC, S_LD_MEAN, S_MEAN_DIV, S_ST_MEAN, S_MUL1, S_LD_MUL2, S_MUL2,
    S_LD_VAR, S_VAR_DIV, S_ST_VAR, S_LD_SD, S_SD_SQ, S_ST_SD, S_SE_DIV,
    S_LD_SQ2, S_SE_SQ, S_ST_SE, S_LD_HW, S_HW_MUL, S_ST_HW, S_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_gt1;
  } dp_status_t;

  localparam logic [15:0] T_ROM [3][T_ROWS] = '{
    '{16'd6314,16'd2920,16'd2353,16'd2132,16'd2015,16'd1943,16'd1895,16'd1860,
      16'd1833,16'd1812,16'd1796,16'd1782,16'd1771,16'd1761,16'd1753,16'd1746,
      16'd1740,16'd1734,16'd1729,16'd1725,16'd1721,16'd1717,16'd1714,16'd1711,
      16'd1708,16'd1706,16'd1703,16'd1701,16'd1699,16'd1697,16'd1696,16'd1694,
      16'd1692,16'd1691,16'd1690,16'd1688,16'd1687,16'd1686,16'd1685,16'd1684,
      16'd1683,16'd1682,16'd1681,16'd1680,16'd1679,16'd1679,16'd1678,16'd1677,
      16'd1677,16'd1676,16'd1675,16'd1675,16'd1674,16'd1674,16'd1673,16'd1673,
      16'd1672,16'd1672,16'd1671,16'd1671,16'd1670,16'd1670,16'd1669,16'd1669,
      16'd1669,16'd1668,16'd1668,16'd1668,16'd1667,16'd1667,16'd1667,16'd1666,
      16'd1666,16'd1666,16'd1665,16'd1665,16'd1665,16'd1665,16'd1664,16'd1664,
      16'd1664,16'd1664,16'd1663,16'd1663,16'd1663,16'd1663,16'd1663,16'd1662,
      16'd1662,16'd1662,16'd1662,16'd1662,16'd1661,16'd1661,16'd1661,16'd1661,
      16'd1661,16'd1661,16'd1660},
    '{16'd12706,16'd4303,16'd3182,16'd2776,16'd2571,16'd2447,16'd2365,16'd2306,
      16'd2262,16'd2228,16'd2201,16'd2179,16'd2160,16'd2145,16'd2131,16'd2120,
      16'd2110,16'd2101,16'd2093,16'd2086,16'd2080,16'd2074,16'd2069,16'd2064,
      16'd2060,16'd2056,16'd2052,16'd2048,16'd2045,16'd2042,16'd2040,16'd2037,
      16'd2035,16'd2032,16'd2030,16'd2028,16'd2026,16'd2024,16'd2023,16'd2021,
      16'd2020,16'd2018,16'd2017,16'd2015,16'd2014,16'd2013,16'd2012,16'd2011,
      16'd2010,16'd2009,16'd2008,16'd2007,16'd2006,16'd2005,16'd2004,16'd2003,
      16'd2002,16'd2002,16'd2001,16'd2000,16'd2000,16'd1999,16'd1998,16'd1998,
      16'd1997,16'd1997,16'd1996,16'd1995,16'd1995,16'd1994,16'd1994,16'd1993,
      16'd1993,16'd1993,16'd1992,16'd1992,16'd1991,16'd1991,16'd1990,16'd1990,
      16'd1990,16'd1989,16'd1989,16'd1989,16'd1988,16'd1988,16'd1988,16'd1987,
      16'd1987,16'd1987,16'd1986,16'd1986,16'd1986,16'd1986,16'd1985,16'd1985,
      16'd1985,16'd1984,16'd1984},
    '{16'd63657,16'd9925,16'd5841,16'd4604,16'd4032,16'd3707,16'd3499,16'd3355,
      16'd3250,16'd3169,16'd3106,16'd3055,16'd3012,16'd2977,16'd2947,16'd2921,
      16'd2898,16'd2878,16'd2861,16'd2845,16'd2831,16'd2819,16'd2807,16'd2797,
      16'd2787,16'd2779,16'd2771,16'd2763,16'd2756,16'd2750,16'd2744,16'd2738,
      16'd2733,16'd2728,16'd2724,16'd2719,16'd2715,16'd2712,16'd2708,16'd2704,
      16'd2701,16'd2698,16'd2695,16'd2692,16'd2690,16'd2687,16'd2685,16'd2682,
      16'd2680,16'd2678,16'd2676,16'd2674,16'd2672,16'd2670,16'd2668,16'd2667,
      16'd2665,16'd2663,16'd2662,16'd2660,16'd2659,16'd2657,16'd2656,16'd2655,
      16'd2654,16'd2652,16'd2651,16'd2650,16'd2649,16'd2648,16'd2647,16'd2646,
      16'd2645,16'd2644,16'd2643,16'd2642,16'd2641,16'd2640,16'd2640,16'd2639,
      16'd2638,16'd2637,16'd2636,16'd2636,16'd2635,16'd2634,16'd2634,16'd2633,
      16'd2632,16'd2632,16'd2631,16'd2630,16'd2630,16'd2629,16'd2629,16'd2628,
      16'd2627,16'd2627,16'd2626}
  };

  localparam logic [15:0] T_ASYM [3] = '{16'd1645, 16'd1960, 16'd2576};

  function automatic logic [1:0] lvl_row(input logic [1:0] lvl);
    logic [1:0] r;
    case (conf_lvl_e'(lvl))
      LVL_90:  r = 2'd0;
      LVL_95:  r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rsc_ctrl.sv
`default_nettype none
module rsc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               last_sample_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire rsc_pkg::dp_status_t status_i,
  output rsc_pkg::dp_cmd_t        cmd_o
);
  import rsc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  function automatic logic done(input logic [CNT_W-1:0] c, input int unsigned n);
    return c == CNT_W'(n - 1);
  endfunction

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_ACC: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCUM;
          if (last_sample_i) state_d = S_LD_MEAN;
        end
      end
      S_LD_MEAN: begin
        cmd_o.op = OP_LD_MEAN;
        cnt_d    = '0;
        state_d  = S_MEAN_DIV;
      end
      S_MEAN_DIV, S_VAR_DIV, S_SE_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (done(cnt_q, DIV_STEPS)) begin
          cnt_d = '0;
          case (state_q)
            S_MEAN_DIV: state_d = S_ST_MEAN;
            S_VAR_DIV:  state_d = S_ST_VAR;
            default:    state_d = S_LD_SQ2;
          endcase
        end
      end
      S_ST_MEAN: begin
        cmd_o.op = OP_ST_MEAN;
        state_d  = status_i.n_gt1 ? S_MUL1 : S_OUT;
      end
      S_MUL1, S_MUL2, S_HW_MUL: begin
        cmd_o.op = (state_q == S_MUL2) ? OP_MUL_SUB : OP_MUL_ADD;
        cnt_d    = cnt_q + 1'b1;
        if (done(cnt_q, MUL_STEPS)) begin
          cnt_d = '0;
          case (state_q)
            S_MUL1:  state_d = S_LD_MUL2;
            S_MUL2:  state_d = S_LD_VAR;
            default: state_d = S_ST_HW;
          endcase
        end
      end
      S_LD_MUL2: begin
        cmd_o.op = OP_LD_MUL2;
        state_d  = S_MUL2;
      end
      S_LD_VAR: begin
        cmd_o.op = OP_LD_VAR;
        state_d  = S_VAR_DIV;
      end
      S_ST_VAR: begin
        cmd_o.op = OP_ST_VAR;
        state_d  = S_LD_SD;
      end
      S_LD_SD: begin
        cmd_o.op = OP_LD_SD;
        state_d  = S_SD_SQ;
      end
      S_SD_SQ, S_SE_SQ: begin
        cmd_o.op = OP_SQ_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (done(cnt_q, SQRT_STEPS)) begin
          cnt_d   = '0;
          state_d = (state_q == S_SD_SQ) ? S_ST_SD : S_ST_SE;
        end
      end
      S_ST_SD: begin
        cmd_o.op = OP_ST_SD;
        state_d  = S_SE_DIV;
      end
      S_LD_SQ2: begin
        cmd_o.op = OP_LD_SQ2;
        state_d  = S_SE_SQ;
      end
      S_ST_SE: begin
        cmd_o.op = OP_ST_SE;
        state_d  = S_LD_HW;
      end
      S_LD_HW: begin
        cmd_o.op = OP_LD_HW;
        state_d  = S_HW_MUL;
      end
      S_ST_HW: begin
        cmd_o.op = OP_ST_HW;
        state_d  = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.op = OP_CLEAR;
          state_d  = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/rsc_datapath.sv
`default_nettype none
module rsc_datapath #(
  parameter int unsigned TABLE_LIMIT = 100,
  parameter int unsigned MAX_COUNT   = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rsc_pkg::dp_cmd_t   cmd_i,
  output rsc_pkg::dp_status_t     status_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_wdata_i,
  input  wire logic [23:0]        sample_value_i,
  output logic [16:0]             sample_count_o,
  output logic [23:0]             min_value_o,
  output logic signed [16:0]      min_position_o,
  output logic [23:0]             max_value_o,
  output logic signed [16:0]      max_position_o,
  output logic [31:0]             mean_value_o,
  output logic [55:0]             variance_value_o,
  output logic [31:0]             std_deviation_o,
  output logic [31:0]             std_error_o,
  output logic [31:0]             half_width_o,
  output logic signed [32:0]      lower_bound_o,
  output logic [32:0]             upper_bound_o
);
  import rsc_pkg::*;

  localparam logic [23:0] SMASK = 24'((25'd1 << SAMPLE_BITS) - 25'd1);
  localparam logic [16:0] CNT_MAX = 17'(MAX_COUNT);
  localparam logic [16:0] T_LIM   = 17'(TABLE_LIMIT);

  logic [1:0]  lvl_q;
  logic [39:0] sum_q;
  logic [63:0] sq_q;
  logic [23:0] min_q, max_q;
  logic [16:0] minpos_q, maxpos_q, n_q;

  logic [31:0] mean_q, sd_q, se_q, hw_q;
  logic [55:0] var_q;

  logic [88:0] dvd_q;
  logic [32:0] rem_q;
  logic [31:0] dvs_q;
  logic [88:0] acc_q, mcand_q;
  logic [39:0] mplier_q;
  logic [63:0] sx_q;
  logic [34:0] srem_q;
  logic [31:0] root_q;
  logic        hw_sat_q;

  logic [23:0] v;
  logic [47:0] v_sq;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [34:0] srem_sh, strial;
  logic        sq_ge;
  logic [33:0] nn1;
  logic [15:0] t_val;
  logic [6:0]  t_idx;
  logic [47:0] hw_prod;

  assign v      = sample_value_i & SMASK;
  assign v_sq   = v * v;
  assign rem_sh = {rem_q[31:0], dvd_q[88]};
  assign div_ge = rem_sh >= {1'b0, dvs_q};
  assign srem_sh = {srem_q[32:0], sx_q[63:62]};
  assign strial  = {1'b0, root_q, 2'b01};
  assign sq_ge   = srem_sh >= strial;
  assign nn1     = n_q * (n_q - 17'd1);
  assign t_idx   = 7'(n_q - 17'd2);
  assign t_val   = (n_q <= T_LIM) ? T_ROM[lvl_row(lvl_q)][t_idx] : T_ASYM[lvl_row(lvl_q)];
  assign hw_prod = se_q * t_val;

  assign status_o.n_gt1 = n_q > 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q    <= LVL_95;
      sum_q    <= '0;
      sq_q     <= '0;
      min_q    <= SMASK;
      max_q    <= '0;
      minpos_q <= '1;
      maxpos_q <= '1;
      n_q      <= '0;
    end else begin
      if (cfg_we_i) lvl_q <= cfg_wdata_i;
      case (cmd_i.op)
        OP_ACCUM: begin
          if (n_q < CNT_MAX) begin
            sum_q <= sum_q + 40'(v);
            sq_q  <= sq_q + 64'(v_sq);
            if (n_q == '0 || v < min_q) begin
              min_q    <= v;
              minpos_q <= n_q;
            end
            if (v > max_q) begin
              max_q    <= v;
              maxpos_q <= n_q;
            end
            n_q <= n_q + 17'd1;
          end
        end
        OP_CLEAR: begin
          sum_q    <= '0;
          sq_q     <= '0;
          min_q    <= SMASK;
          max_q    <= '0;
          minpos_q <= '1;
          maxpos_q <= '1;
          n_q      <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LD_MEAN: begin
        dvd_q <= 89'({sum_q, 8'd0});
        dvs_q <= 32'(n_q);
        rem_q <= '0;
        var_q <= '0;
        sd_q  <= '0;
        se_q  <= '0;
        hw_q  <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        dvd_q <= {dvd_q[87:0], div_ge};
      end
      OP_ST_MEAN: begin
        mean_q   <= dvd_q[31:0];
        acc_q    <= '0;
        mcand_q  <= 89'(sq_q);
        mplier_q <= 40'(n_q);
      end
      OP_MUL_ADD, OP_MUL_SUB: begin
        if (mplier_q[0]) begin
          acc_q <= (cmd_i.op == OP_MUL_ADD) ? acc_q + mcand_q : acc_q - mcand_q;
        end
        mcand_q  <= {mcand_q[87:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[39:1]};
      end
      OP_LD_MUL2: begin
        mcand_q  <= 89'(sum_q);
        mplier_q <= sum_q;
      end
      OP_LD_VAR: begin
        dvd_q <= {acc_q[80:0], 8'd0};
        dvs_q <= nn1[31:0];
        rem_q <= '0;
      end
      OP_ST_VAR: var_q <= (|dvd_q[88:56]) ? '1 : dvd_q[55:0];
      OP_LD_SD: begin
        sx_q   <= {var_q, 8'd0};
        srem_q <= '0;
        root_q <= '0;
      end
      OP_SQ_STEP: begin
        srem_q <= sq_ge ? (srem_sh - strial) : srem_sh;
        root_q <= {root_q[30:0], sq_ge};
        sx_q   <= {sx_q[61:0], 2'b00};
      end
      OP_ST_SD: begin
        sd_q  <= root_q;
        dvd_q <= 89'({var_q, 8'd0});
        dvs_q <= 32'(n_q);
        rem_q <= '0;
      end
      OP_LD_SQ2: begin
        sx_q   <= dvd_q[63:0];
        srem_q <= '0;
        root_q <= '0;
      end
      OP_ST_SE: se_q <= root_q;
      OP_LD_HW: begin
        acc_q    <= '0;
        mcand_q  <= 89'(HW_RECIP);
        mplier_q <= {1'b0, hw_prod[41:3]};
        hw_sat_q <= hw_prod >= HW_SAT;
      end
      OP_ST_HW: hw_q <= hw_sat_q ? '1 : acc_q[77:46];
      default: ;
    endcase
  end

  assign sample_count_o   = n_q;
  assign min_value_o      = min_q;
  assign min_position_o   = minpos_q;
  assign max_value_o      = max_q;
  assign max_position_o   = maxpos_q;
  assign mean_value_o     = mean_q;
  assign variance_value_o = var_q;
  assign std_deviation_o  = sd_q;
  assign std_error_o      = se_q;
  assign half_width_o     = hw_q;
  assign lower_bound_o    = {1'b0, mean_q} - {1'b0, hw_q};
  assign upper_bound_o    = {1'b0, mean_q} + {1'b0, hw_q};

endmodule
`default_nettype wire

>>> rtl/core/running_stats_confidence_unit.sv
// Accumulation: one sample per cycle, in_ready_o high while collecting a set.
// On the last sample the block stops taking input and runs one shared restoring
// divider, shift-add multiplier and root unit in turn; the divide by 1000 is a
// reciprocal multiply on the shared multiplier.
// out_valid_o follows the mean for a single-sample set and the half-width otherwise.
// Reset (async, active low) clears all sums and extremes; level resets to 95 %.
`default_nettype none
module running_stats_confidence_unit #(
  parameter int unsigned TABLE_LIMIT = 100,
  parameter int unsigned MAX_COUNT   = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [23:0]       sample_value_i,
  input  wire logic              last_sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [16:0]            sample_count_o,
  output logic [23:0]            min_value_o,
  output logic signed [16:0]     min_position_o,
  output logic [23:0]            max_value_o,
  output logic signed [16:0]     max_position_o,
  output logic [31:0]            mean_value_o,
  output logic [55:0]            variance_value_o,
  output logic [31:0]            std_deviation_o,
  output logic [31:0]            std_error_o,
  output logic [31:0]            half_width_o,
  output logic signed [32:0]     lower_bound_o,
  output logic [32:0]            upper_bound_o
);
  import rsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rsc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_sample_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .status_i(status), .cmd_o(cmd)
  );

  rsc_datapath #(
    .TABLE_LIMIT(TABLE_LIMIT), .MAX_COUNT(MAX_COUNT), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .cfg_we_i, .cfg_wdata_i,
    .sample_value_i, .sample_count_o, .min_value_o, .min_position_o,
    .max_value_o, .max_position_o, .mean_value_o, .variance_value_o,
    .std_deviation_o, .std_error_o, .half_width_o, .lower_bound_o, .upper_bound_o
  );

endmodule
`default_nettype wire

>>> rtl/core/rsc_checker.sv
`default_nettype none
module rsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [16:0] sample_count_o,
  input wire logic [31:0] mean_value_o,
  input wire logic [31:0] half_width_o,
  input wire logic [32:0] upper_bound_o
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input open while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_value_o))
    else $error("result transaction dropped or changed");

  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o) else $error("no return to accumulate");

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != 17'd0) else $error("empty set reported");

  a_ub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> upper_bound_o == {1'b0, mean_value_o} + {1'b0, half_width_o})
    else $error("upper bound mismatch");

endmodule

bind running_stats_confidence_unit rsc_checker u_rsc_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .sample_count_o, .mean_value_o, .half_width_o, .upper_bound_o
);
`default_nettype wire
